// ===== src/asbc_pkg.sv =====
// Package: shared types, S-boxes and GF(2^8) helpers for the block cipher.
`timescale 1ns / 1ps
`default_nettype none
package asbc_pkg;

    typedef logic [7:0] t_byte;
    typedef t_byte [15:0] t_state;

    // Pipeline control carried next to the state
    typedef struct packed {
        logic valid;
        logic decrypt;
    } t_ctl;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] TWEAK_STEP = 8'h11;

    localparam logic [7:0] FWD_SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    // Multiply by x in GF(2^8)
    function automatic t_byte xtime(input t_byte a);
        xtime = a[7] ? ((a << 1) ^ GF_POLY) : (a << 1);
    endfunction

    // Split into bytes, byte 0 in the top bits of the high word
    function automatic t_state unpack(input logic [63:0] hi, input logic [63:0] lo);
        t_state s;
        for (int i = 0; i < 8; i++) begin
            s[i]     = hi[56-8*i +: 8];
            s[8 + i] = lo[56-8*i +: 8];
        end
        unpack = s;
    endfunction

    // Round key r: key rotated by r bytes, each byte XOR r*0x11
    function automatic t_state round_key(input t_state k, input logic [3:0] r);
        t_state rk;
        t_byte tw;
        tw = 8'({4'd0, r} * TWEAK_STEP);
        for (int i = 0; i < 16; i++) begin
            rk[i] = k[4'(i + int'(r))] ^ tw;
        end
        round_key = rk;
    endfunction

endpackage
`default_nettype wire

// ===== src/asbc_stream_if.sv =====
// Interface: valid/ready stream channel carrying one 128-bit block.
`timescale 1ns / 1ps
`default_nettype none
interface asbc_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        decrypt;

    modport source (output valid, output block_high, output block_low, output decrypt,
                    input ready);
    modport sink   (input valid, input block_high, input block_low, input decrypt,
                    output ready);
endinterface
`default_nettype wire

// ===== src/asbc_result_if.sv =====
// Interface: valid/ready stream channel carrying one 128-bit result.
`timescale 1ns / 1ps
`default_nettype none
interface asbc_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;

    modport source (output valid, output result_high, output result_low, input ready);
    modport sink   (input valid, input result_high, input result_low, output ready);
endinterface
`default_nettype wire

// ===== src/aes_style_block_cipher.sv =====
// Top level: key registers, whitening stage, round pipeline and output stage.
`timescale 1ns / 1ps
`default_nettype none
// Fully unrolled cipher pipeline: one whitening stage followed by one register stage per
// round, ROUNDS+1 stages in all; a block is registered in each stage in turn, and a new
// block is taken every cycle while out is not stalled. Each round stage but the last holds
// one S-box layer and one mix layer. The pipeline moves as one: when the output stage
// holds a result that is not taken, all stages hold and in.ready drops, so nothing is lost
// or repeated. Keys must be written through the config port only while the block is idle,
// which the block does not enforce; index 0 is key_high, index 1 key_low, others are
// ignored. Decrypt pairs with a key add of round ROUNDS at entry and round 0 at the end.
module aes_style_block_cipher
    import asbc_pkg::*;
#(
    parameter int ROUNDS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [63:0] i_cfg_data,
    asbc_stream_if.sink      in,
    asbc_result_if.source    out
);
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    logic [63:0] r_key_high, r_key_low;
    t_state      key;
    logic        adv;

    t_ctl   ctl [ROUNDS+1];
    t_state st  [ROUNDS+1];
    t_ctl   r_ctl0;
    t_state r_st0;

    // Key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end
    assign key = unpack(r_key_high, r_key_low);

    // Whole pipeline advances unless the output is full and stalled
    assign adv      = !ctl[ROUNDS].valid || out.ready;
    assign in.ready = adv;

    // Entry stage: encrypt adds round key 0, decrypt adds key ROUNDS then InvShift, InvSub
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl0 <= '0;
        end else if (adv) begin
            r_ctl0 <= '{valid: in.valid, decrypt: in.decrypt};
        end
    end

    always_ff @(posedge i_clk) begin
        t_state s, k0, kr, sh;
        if (adv) begin
            s  = unpack(in.block_high, in.block_low);
            k0 = round_key(key, 4'd0);
            kr = round_key(key, 4'(ROUNDS));
            if (!in.decrypt) begin
                for (int i = 0; i < 16; i++) r_st0[i] <= s[i] ^ k0[i];
            end else begin
                for (int i = 0; i < 16; i++) s[i] = s[i] ^ kr[i];
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++)
                        sh[r + 4*c] = s[r + 4*((c + 4 - r) & 3)];
                for (int i = 0; i < 16; i++) r_st0[i] <= INV_SBOX[sh[i]];
            end
        end
    end

    assign ctl[0] = r_ctl0;
    assign st[0]  = r_st0;

    // Round stages: encrypt round g+1, decrypt round ROUNDS-1-g
    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        asbc_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_enc_r (4'(g + 1)),
            .i_dec_r (4'(ROUNDS - 1 - g)),
            .i_last  (g == ROUNDS - 1),
            .i_key   (key),
            .i_ctl   (ctl[g]),
            .i_state (st[g]),
            .o_ctl   (ctl[g+1]),
            .o_state (st[g+1])
        );
    end

    // Output: the final stage register is the output register
    assign out.valid = ctl[ROUNDS].valid;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            out.result_high[56-8*i +: 8] = st[ROUNDS][i];
            out.result_low[56-8*i +: 8]  = st[ROUNDS][8+i];
        end
    end

    // Checks
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.result_high)
                                    && $stable(out.result_low))
        else $error("result changed under stall");
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !out.valid |-> in.ready)
        else $error("stalled with empty output");
    a_entry_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in.valid && in.ready |=> ctl[0].valid)
        else $error("accepted block not in entry stage");
endmodule
`default_nettype wire

// ===== src/asbc_round.sv =====
// One pipelined round, either direction: key add, shift/sub and mix per mode.
`timescale 1ns / 1ps
`default_nettype none
module asbc_round
    import asbc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_en,
    input  wire logic [3:0] i_enc_r,    // encrypt round number
    input  wire logic [3:0] i_dec_r,    // decrypt round number
    input  wire logic       i_last,     // encrypt: no mix; decrypt: final key add only
    input  wire t_state     i_key,
    input  wire t_ctl       i_ctl,
    input  wire t_state     i_state,
    output t_ctl            o_ctl,
    output t_state          o_state
);
    t_ctl   r_ctl;
    t_state r_state;
    t_state n_state;

    // Encrypt round: Sub, Shift, Mix (unless last), AddKey(r).
    // Decrypt round: AddKey(r), InvMix, InvShift, InvSub; only AddKey(0) on the last.
    always_comb begin
        t_state sb, sh, mx, ek, dk, rk_e, rk_d;
        t_byte  a0, a1, a2, a3, x2, x4, x8;
        sb = '0; sh = '0; mx = '0; ek = '0; dk = '0;
        a0 = '0; a1 = '0; a2 = '0; a3 = '0; x2 = '0; x4 = '0; x8 = '0;
        rk_e = round_key(i_key, i_enc_r);
        rk_d = round_key(i_key, i_dec_r);
        if (!i_ctl.decrypt) begin
            for (int i = 0; i < 16; i++) sb[i] = FWD_SBOX[i_state[i]];
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[r + 4*c] = sb[r + 4*((c + r) & 3)];
            for (int j = 0; j < 4; j++) begin
                a0 = sh[j]; a1 = sh[4+j]; a2 = sh[8+j]; a3 = sh[12+j];
                mx[j]    = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                mx[4+j]  = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                mx[8+j]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                mx[12+j] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
            ek = i_last ? sh : mx;
            for (int i = 0; i < 16; i++) n_state[i] = ek[i] ^ rk_e[i];
        end else begin
            for (int i = 0; i < 16; i++) dk[i] = i_state[i] ^ rk_d[i];
            // inverse mix: coefficients 14,11,13,9 rotated per row
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 4; i++) begin
                    mx[4*i+j] = 8'h00;
                    for (int k = 0; k < 4; k++) begin
                        a0 = dk[4*k+j];
                        x2 = xtime(a0); x4 = xtime(x2); x8 = xtime(x4);
                        case ((k + 4 - i) & 3)
                            0:       mx[4*i+j] ^= x8 ^ x4 ^ x2;
                            1:       mx[4*i+j] ^= x8 ^ x2 ^ a0;
                            2:       mx[4*i+j] ^= x8 ^ x4 ^ a0;
                            default: mx[4*i+j] ^= x8 ^ a0;
                        endcase
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    sh[r + 4*c] = mx[r + 4*((c + 4 - r) & 3)];
            for (int i = 0; i < 16; i++) sb[i] = INV_SBOX[sh[i]];
            // last stage runs with round 0, so the key add alone finishes the block
            for (int i = 0; i < 16; i++) n_state[i] = i_last ? dk[i] : sb[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_state = r_state;
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Testbench: self-checking stream test of the AES-style block cipher.
`timescale 1ns / 1ps
module tb_top;
    import asbc_pkg::*;

    localparam int NUM_ROUNDS = 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic CFG_KEY_HIGH = 1'b0;
    localparam logic CFG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        dec;
    } t_block_txn;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } t_cipher_out;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [63:0] i_cfg_data;

    asbc_stream_if blk_if ();
    asbc_result_if res_if ();

    aes_style_block_cipher #(.ROUNDS(NUM_ROUNDS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .in(blk_if.sink), .out(res_if.source)
    );

    // Local key copy and queues
    logic [63:0] key_hi_q, key_lo_q;
    t_block_txn  pending_blocks[$];
    t_cipher_out expected_blocks[$];
    int          mismatch_count;
    int          result_count;
    int          cycle_count;
    int          stall_hold;
    int          enc_count, dec_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // GF(2^8) multiply, shift-and-add
    function automatic logic [7:0] gf_mult(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        acc = 8'h00;
        for (int b = 0; b < 8; b++) begin
            if (y[b]) acc ^= x;
            x = x[7] ? ((x << 1) ^ 8'h1b) : (x << 1);
        end
        return acc;
    endfunction

    // Full cipher on a 16-byte array, byte 0 first
    function automatic t_cipher_out cipher_block(input t_block_txn t, input logic [63:0] kh,
                                                 input logic [63:0] kl);
        logic [7:0] s[16], k[16], tmp[16];
        logic [7:0] m[4], tw, acc;
        int r, ri, c, src;
        t_cipher_out o;
        for (int i = 0; i < 8; i++) begin
            s[i] = t.hi[56-8*i +: 8];  s[8+i] = t.lo[56-8*i +: 8];
            k[i] = kh[56-8*i +: 8];    k[8+i] = kl[56-8*i +: 8];
        end
        if (t.dec) m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int step = 0; step <= NUM_ROUNDS; step++) begin
            r = t.dec ? NUM_ROUNDS - step : step;
            // decrypt: key add, then inverse mix (except first), inverse shift/sub; last: key add only
            if (t.dec || step == 0) begin
                tw = 8'(r * 8'h11);
                for (int i = 0; i < 16; i++) s[i] ^= k[(i + r) & 15] ^ tw;
                if (t.dec && step == NUM_ROUNDS) break;
                if (t.dec && step != 0) begin
                    for (int i = 0; i < 4; i++)
                        for (int j = 0; j < 4; j++) begin
                            acc = 8'h00;
                            for (int q = 0; q < 4; q++)
                                acc ^= gf_mult(m[(q + 4 - i) & 3], s[4*q + j]);
                            tmp[4*i + j] = acc;
                        end
                    s = tmp;
                end
                if (t.dec) begin
                    for (c = 0; c < 4; c++)
                        for (ri = 0; ri < 4; ri++) begin
                            src = (c + 4 - ri) & 3;
                            tmp[ri + 4*c] = s[ri + 4*src];
                        end
                    for (int i = 0; i < 16; i++) s[i] = INV_SBOX[tmp[i]];
                end
            end else begin
                // encrypt round: sub, shift, mix unless last, key add
                for (int i = 0; i < 16; i++) s[i] = FWD_SBOX[s[i]];
                for (c = 0; c < 4; c++)
                    for (ri = 0; ri < 4; ri++) tmp[ri + 4*c] = s[ri + 4*((c + ri) & 3)];
                s = tmp;
                if (step != NUM_ROUNDS) begin
                    for (int i = 0; i < 4; i++)
                        for (int j = 0; j < 4; j++) begin
                            acc = 8'h00;
                            for (int q = 0; q < 4; q++)
                                acc ^= gf_mult(m[(q + 4 - i) & 3], s[4*q + j]);
                            tmp[4*i + j] = acc;
                        end
                    s = tmp;
                end
                tw = 8'(r * 8'h11);
                for (int i = 0; i < 16; i++) s[i] ^= k[(i + r) & 15] ^ tw;
            end
        end
        for (int i = 0; i < 8; i++) begin
            o.hi[56-8*i +: 8] = s[i];
            o.lo[56-8*i +: 8] = s[8+i];
        end
        return o;
    endfunction

    // Driver: bursts and gaps, pops one transaction per handshake
    int burst_left, gap_left;
    initial begin
        blk_if.valid = 1'b0; blk_if.block_high = '0; blk_if.block_low = '0;
        blk_if.decrypt = 1'b0;
        burst_left = 0; gap_left = 0;
    end
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blk_if.valid <= 1'b0;
        end else begin
            if (blk_if.valid && blk_if.ready) begin
                expected_blocks.push_back(cipher_block(pending_blocks.pop_front(),
                                                       key_hi_q, key_lo_q));
            end
            // the accepted transaction is already popped, so the head is the next one
            if (!(blk_if.valid && !blk_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    blk_if.valid <= 1'b0;
                end else if (pending_blocks.size() > 0) begin
                    blk_if.valid      <= 1'b1;
                    blk_if.block_high <= pending_blocks[0].hi;
                    blk_if.block_low  <= pending_blocks[0].lo;
                    blk_if.decrypt    <= pending_blocks[0].dec;
                    if (burst_left > 0) burst_left--;
                    else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
                    end
                end else begin
                    blk_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver stall pattern plus one long hold-off
    logic [15:0] stall_pattern;
    int          stall_phase;
    initial begin
        res_if.ready = 1'b0; stall_phase = 0; stall_hold = 0;
        stall_pattern = 16'b1011_0111_1100_1111;
    end
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            res_if.ready <= 1'b0;
        end else if (stall_phase % 600 < 200) begin
            res_if.ready <= 1'b1;
        end else if (stall_phase % 600 < 400) begin
            res_if.ready <= stall_pattern[stall_phase % 16];
        end else begin
            res_if.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Monitor: compare every accepted result with the oldest expectation
    t_cipher_out exp_r;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            result_count <= result_count + 1;
            if (expected_blocks.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result %h %h", res_if.result_high, res_if.result_low);
            end else begin
                exp_r = expected_blocks.pop_front();
                if (res_if.result_high !== exp_r.hi || res_if.result_low !== exp_r.lo) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h %h, got %h %h", exp_r.hi, exp_r.lo,
                                 res_if.result_high, res_if.result_low);
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic write_key(input logic idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_KEY_HIGH) key_hi_q <= val;
        else key_lo_q <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo, input logic dec);
        t_block_txn t;
        t.hi = hi; t.lo = lo; t.dec = dec;
        pending_blocks.push_back(t);
        if (dec) dec_count++;
        else enc_count++;
    endtask

    // Wait until the pipeline has drained and give it margin before key writes
    task automatic drain_pipe();
        while (pending_blocks.size() > 0 || expected_blocks.size() > 0 || blk_if.valid)
            @(posedge i_clk);
        repeat (NUM_ROUNDS + 4) @(posedge i_clk);
    endtask

    logic [63:0] rh, rl;
    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_idx = CFG_KEY_HIGH; i_cfg_data = '0;
        key_hi_q = '0; key_lo_q = '0; mismatch_count = 0; result_count = 0;
        cycle_count = 0; enc_count = 0; dec_count = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset key, then all-ones key, then a fixed key; extremes, both directions
        queue_block('0, '0, 1'b0);
        queue_block('0, '0, 1'b1);
        queue_block('1, '1, 1'b0);
        queue_block('1, '1, 1'b1);
        queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
        queue_block(64'h8000000000000000, 64'h0000000000000001, 1'b1);
        drain_pipe();
        write_key(CFG_KEY_HIGH, '1);
        write_key(CFG_KEY_LOW, '1);
        queue_block('0, '0, 1'b0);
        queue_block('1, '1, 1'b1);
        queue_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0);
        queue_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b1);
        drain_pipe();
        write_key(CFG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key(CFG_KEY_LOW, 64'habf7158809cf4f3c);
        queue_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b0);
        queue_block(64'h3243f6a8885a308d, 64'h313198a2e0370734, 1'b1);

        // Random phases, each with a new key (all zeros in the last); the first one faces a long hold-off
        for (int ph = 0; ph < 6; ph++) begin
            drain_pipe();
            if (ph == 5) begin
                write_key(CFG_KEY_HIGH, '0);
                write_key(CFG_KEY_LOW, '0);
            end else begin
                write_key(CFG_KEY_HIGH, {$urandom, $urandom});
                write_key(CFG_KEY_LOW, {$urandom, $urandom});
            end
            if (ph == 0) stall_hold = 300;
            for (int n = 0; n < 322; n++) begin
                rh = {$urandom, $urandom};
                rl = {$urandom, $urandom};
                queue_block(rh, rl, $urandom_range(0, 1));
            end
        end
        drain_pipe();

        $display("covered %0d encrypt and %0d decrypt blocks, %0d results, 9 key settings",
                 enc_count, dec_count, result_count);
        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
